### rtl/abts_pkg.sv
package abts_pkg;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_MUL5,
		ST_MUL6,
		ST_MUL7,
		ST_CHK1,
		ST_CHK2,
		ST_DIVR,
		ST_TMUL,
		ST_TPREP,
		ST_TLO,
		ST_THI,
		ST_TSUM,
		ST_SAT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// divider datapath
	localparam int DIV_W = 48;
	localparam int QUO_W = 29;

	// bus actions
	localparam logic [1:0] ACT_CFG  = 2'd0;
	localparam logic [1:0] ACT_PTR  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_SKIP = 2'd3;

	// phases
	localparam logic [1:0] PH_CFG = 2'd0;
	localparam logic [1:0] PH_PTR = 2'd1;
	localparam logic [1:0] PH_READ = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MUX0 = 3'd0;
	localparam logic [2:0] REG_MUX1 = 3'd1;
	localparam logic [2:0] REG_MUX2 = 3'd2;
	localparam logic [2:0] REG_RATE = 3'd3;
	localparam logic [2:0] REG_R1   = 3'd4;
	localparam logic [2:0] REG_R2   = 3'd5;
	localparam logic [2:0] REG_V0   = 3'd6;

	// scale factors
	localparam logic [29:0] VOLT_SCALE = 30'd32767;
	localparam logic [18:0] TEMP_GAIN  = 19'd258137;
	// offset 2^18 * D, minus the intercept, plus half of D for rounding
	localparam longint TEMP_OFF = 64'sd262144 * 64'sd655360000
		- 64'sd257990783 * 64'sd65536 + 64'sd327680000;
	// D is 625 * 2^20; floor(x / 625) is (x * TEMP_RECIP) >> TEMP_SHIFT for x below 2^28
	localparam logic [29:0] TEMP_RECIP = 30'd109951163;
	localparam int          TEMP_SHIFT = 36;

	localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
	localparam logic signed [15:0] TEMP_MIN = -16'sh8000;

endpackage

### rtl/abts_div.sv
module abts_div (
	input  logic                          clk,
	input  abts_pkg::div_ctrl_t           ctrl,
	input  logic [abts_pkg::DIV_W-1:0]    rem_init,
	input  logic [abts_pkg::QUO_W-1:0]    bits_init,
	input  logic [abts_pkg::DIV_W-1:0]    divisor,
	output logic [abts_pkg::QUO_W-1:0]    quotient
);
	import abts_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [QUO_W-1:0] bits_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_sub;
	logic             ge;

	// restoring division, one quotient bit a cycle while step is high
	always_comb begin
		rem_sh  = {rem_q, bits_q[QUO_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		ge      = !rem_sub[DIV_W];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q  <= rem_init;
			bits_q <= bits_init;
			dvs_q  <= divisor;
		end else if (ctrl.step) begin
			rem_q  <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			bits_q <= {bits_q[QUO_W-2:0], 1'b0};
			quo_q  <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

### rtl/adc_bridge_temperature_scanner_top.sv
// channel  | direction | contents
// s_*      | in        | tuser: bus_error; tdata[15:0]: adc_code
// m_*      | out       | tuser: bus_action; tdata: channel, config_high, config_low,
//          |           |   temp_valid, temperature_centi, range_error
// wr_*     | in        | register write: index 0..6, data up to 16 bits
//
// config write, pointer write and skip words go from idle straight to the done state; a read
// word makes nine passes through the shared 30x19 multiplier, two range checks, 29 divider
// steps for the resistance and a reciprocal multiply for the temperature scaling, and a
// range check can end it early. reset clears phase, channel, registers to their defaults
// and the output valid. s_tready is high only while idle; a finished word waits in the
// output register, and the sequencer holds while that is full and not taken.
module adc_bridge_temperature_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // adc_code
	input  logic        s_tuser,   // bus_error
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // channel, config_high, config_low, temp_valid,
	                               // temperature_centi, range_error, zero fill
	output logic [1:0]  m_tuser,   // bus_action
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);
	import abts_pkg::*;

	state_t state_q, state_d;

	logic [1:0]  phase_q, chan_q;
	logic [7:0]  mux0_q, mux1_q, mux2_q, rate_q;
	logic [15:0] r1_q, r2_q;
	logic [12:0] mv_q;

	logic [15:0] code_q;
	logic signed [15:0] n16;
	logic signed [23:0] vq;
	logic [16:0] sum_s;
	logic signed [29:0] diff_v;

	logic signed [29:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [48:0] prod_q;

	logic [27:0]        v0q_q;
	logic signed [41:0] t1_q;
	logic signed [45:0] v0r2_q;
	logic signed [45:0] x_q;
	logic signed [47:0] den_q;
	logic signed [63:0] num_q;
	logic signed [63:0] b_q;
	logic signed [63:0] c_chk;
	logic signed [49:0] tp;
	logic [27:0]        xt_q;
	logic [45:0]        tlo_q;
	logic [55:0]        tacc_q;
	logic signed [19:0] t20;
	logic [4:0]         cnt_q;

	div_ctrl_t        div_ctrl;
	logic [DIV_W-1:0] div_rem_init;
	logic [QUO_W-1:0] div_bits_init;
	logic [DIV_W-1:0] div_divisor;
	logic [QUO_W-1:0] div_quo;

	logic [1:0]  res_action_q, res_chan_q;
	logic [7:0]  res_hi_q, res_lo_q;
	logic        res_tv_q, res_err_q;
	logic [15:0] res_temp_q;

	logic        m_tvalid_q;
	logic [39:0] out_data_q;
	logic [1:0]  out_user_q;

	logic       s_accept, out_load, is_read;
	logic [1:0] ch_cur, ch_next;
	logic [7:0] mux_sel;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign is_read  = !s_tuser && (phase_q != PH_CFG) && (phase_q != PH_PTR);

	assign ch_cur  = (chan_q == 2'd3) ? 2'd2 : chan_q;
	assign ch_next = (ch_cur == 2'd2) ? 2'd0 : ch_cur + 2'd1;

	always_comb begin
		case (ch_cur)
			2'd0:    mux_sel = mux0_q;
			2'd1:    mux_sel = mux1_q;
			default: mux_sel = mux2_q;
		endcase
	end

	// codes at and above half scale count down from full scale
	assign n16    = code_q[15] ? signed'(code_q + 16'd1) : signed'(code_q);
	assign vq     = {n16, 8'h00};
	assign sum_s  = {1'b0, r1_q} + {1'b0, r2_q};
	assign diff_v = signed'({2'b00, v0q_q}) - 30'(vq);
	assign c_chk  = b_q - (64'(den_q) <<< 13);
	assign tp     = 50'(prod_q) + 50'(TEMP_OFF);
	assign t20    = signed'({1'b0, tacc_q[TEMP_SHIFT+18:TEMP_SHIFT]}) - 20'sd262144;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_accept) state_d = is_read ? ST_MUL1 : ST_DONE;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_MUL4;
			ST_MUL4:  state_d = ST_MUL5;
			ST_MUL5:  state_d = ST_MUL6;
			ST_MUL6:  state_d = ST_MUL7;
			ST_MUL7:  state_d = ST_CHK1;
			ST_CHK1:  state_d = (den_q[47] || den_q == '0) ? ST_DONE : ST_CHK2;
			ST_CHK2:  state_d = (!b_q[63] && c_chk[63]) ? ST_DIVR : ST_DONE;
			ST_DIVR:  if (cnt_q == '0) state_d = ST_TMUL;
			ST_TMUL:  state_d = ST_TPREP;
			ST_TPREP: state_d = ST_TLO;
			ST_TLO:   state_d = ST_THI;
			ST_THI:   state_d = ST_TSUM;
			ST_TSUM:  state_d = ST_SAT;
			ST_SAT:   state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		div_ctrl      = '0;
		div_rem_init  = 48'(b_q[60:13]);
		div_bits_init = {b_q[12:0], 16'h0000};
		div_divisor   = 48'(den_q);
		out_load      = 1'b0;
		case (state_q)
			ST_MUL1: begin
				mul_a = signed'(VOLT_SCALE);
				mul_b = signed'(19'(mv_q));
			end
			ST_MUL2: begin
				mul_a = 30'(vq);
				mul_b = signed'(19'(sum_s));
			end
			ST_MUL3: begin
				mul_a = signed'(30'(v0q_q));
				mul_b = signed'(19'(r2_q));
			end
			ST_MUL4: begin
				mul_a = diff_v;
				mul_b = signed'(19'(sum_s));
			end
			ST_MUL5: begin
				mul_a = signed'(30'(x_q[22:0]));
				mul_b = signed'(19'(r1_q));
			end
			ST_MUL6: begin
				mul_a = 30'(signed'(x_q[45:23]));
				mul_b = signed'(19'(r1_q));
			end
			ST_CHK2: div_ctrl.load = !b_q[63] && c_chk[63];
			ST_DIVR: div_ctrl.step = 1'b1;
			// offset quotient back to signed resistance by flipping its top bit
			ST_TMUL: begin
				mul_a = 30'(signed'({~div_quo[QUO_W-1], div_quo[QUO_W-2:0]}));
				mul_b = signed'(TEMP_GAIN);
			end
			// scaled sum over 2^20 times the reciprocal of 625, in two halves
			ST_TLO: begin
				mul_a = signed'(TEMP_RECIP);
				mul_b = signed'({1'b0, xt_q[17:0]});
			end
			ST_THI: begin
				mul_a = signed'(TEMP_RECIP);
				mul_b = signed'(19'(xt_q[27:18]));
			end
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	abts_div u_div (
		.clk       (clk),
		.ctrl      (div_ctrl),
		.rem_init  (div_rem_init),
		.bits_init (div_bits_init),
		.divisor   (div_divisor),
		.quotient  (div_quo)
	);

	// control state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_CFG;
			chan_q     <= 2'd0;
			mux0_q     <= 8'd0;
			mux1_q     <= 8'd0;
			mux2_q     <= 8'd0;
			rate_q     <= 8'd227;
			r1_q       <= 16'd10000;
			r2_q       <= 16'd1000;
			mv_q       <= 13'd5000;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_accept) begin
				if (s_tuser) begin
					phase_q <= PH_CFG;
					chan_q  <= ch_next;
				end else if (phase_q == PH_CFG) begin
					phase_q <= PH_PTR;
				end else if (phase_q == PH_PTR) begin
					phase_q <= PH_READ;
				end else begin
					phase_q <= PH_CFG;
					chan_q  <= ch_next;
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_MUX0: mux0_q <= wr_data[7:0];
					REG_MUX1: mux1_q <= wr_data[7:0];
					REG_MUX2: mux2_q <= wr_data[7:0];
					REG_RATE: rate_q <= wr_data[7:0];
					REG_R1:   r1_q   <= wr_data;
					REG_R2:   r2_q   <= wr_data;
					REG_V0:   mv_q   <= wr_data[12:0];
					default:  ;
				endcase
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: if (s_accept) begin
				code_q       <= s_tdata;
				res_chan_q   <= ch_cur;
				res_hi_q     <= 8'd0;
				res_lo_q     <= 8'd0;
				res_tv_q     <= 1'b0;
				res_temp_q   <= 16'd0;
				res_err_q    <= 1'b0;
				if (s_tuser) begin
					res_action_q <= ACT_SKIP;
				end else if (phase_q == PH_CFG) begin
					res_action_q <= ACT_CFG;
					res_hi_q     <= mux_sel;
					res_lo_q     <= rate_q;
				end else if (phase_q == PH_PTR) begin
					res_action_q <= ACT_PTR;
				end else begin
					res_action_q <= ACT_READ;
				end
			end
			ST_MUL2: v0q_q  <= prod_q[27:0];
			ST_MUL3: t1_q   <= prod_q[41:0];
			ST_MUL4: begin
				v0r2_q <= prod_q[45:0];
				x_q    <= 46'(t1_q) + prod_q[45:0];
			end
			ST_MUL5: den_q <= prod_q[47:0] - 48'(v0r2_q);
			ST_MUL6: num_q <= 64'(prod_q);
			ST_MUL7: num_q <= num_q + (64'(prod_q) <<< 23);
			ST_CHK1: begin
				b_q <= num_q + (64'(den_q) <<< 12);
				if (den_q[47] || den_q == '0)
					res_err_q <= 1'b1;
			end
			ST_CHK2: begin
				cnt_q <= 5'(QUO_W - 1);
				if (b_q[63]) begin
					res_tv_q   <= 1'b1;
					res_temp_q <= TEMP_MIN;
					res_err_q  <= 1'b1;
				end else if (!c_chk[63]) begin
					res_tv_q   <= 1'b1;
					res_temp_q <= TEMP_MAX;
					res_err_q  <= 1'b1;
				end
			end
			ST_DIVR:  cnt_q <= cnt_q - 5'd1;
			// offset sum is never negative, so the low 20 bits just drop
			ST_TPREP: xt_q  <= tp[47:20];
			ST_THI:   tlo_q <= prod_q[45:0];
			ST_TSUM:  tacc_q <= 56'(tlo_q) + (56'(prod_q[37:0]) << 18);
			ST_SAT: begin
				res_tv_q <= 1'b1;
				if (t20 > 20'sd32767) begin
					res_temp_q <= TEMP_MAX;
					res_err_q  <= 1'b1;
				end else if (t20 < -20'sd32768) begin
					res_temp_q <= TEMP_MIN;
					res_err_q  <= 1'b1;
				end else begin
					res_temp_q <= t20[15:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {4'h0, res_err_q, res_temp_q, res_tv_q,
				res_lo_q, res_hi_q, res_chan_q};
			out_user_q <= res_action_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

### tb/sv/tb_adc_bridge_temperature_scanner_top.sv
module tb_adc_bridge_temperature_scanner_top;

	import abts_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		GAP_NONE,
		GAP_SEND,
		GAP_RECV,
		GAP_BOTH
	} gap_mode_t;

	typedef struct {
		logic        err;
		logic [15:0] code;
	} tick_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         chan;
		logic [7:0]         cfg_hi;
		logic [7:0]         cfg_lo;
		logic               tvalid;
		logic signed [15:0] temp;
		logic               rerr;
	} scan_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	// scanner copy: sequencer state and registers
	logic [1:0]  seq_phase;
	logic [1:0]  seq_chan;
	logic [7:0]  mux_q [0:2];
	logic [7:0]  rate_q;
	logic [15:0] r1_q;
	logic [15:0] r2_q;
	logic [12:0] v0_q;

	tick_t      pending_ticks[$];
	scan_word_t expected_words[$];
	gap_mode_t  gap;
	int         hold_left;
	int         n_errors;
	int         quiet_cycles;

	adc_bridge_temperature_scanner_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int idle_pct(gap_mode_t m, bit for_sender);
		if (m == GAP_BOTH)
			return 13;
		if ((m == GAP_SEND && for_sender) || (m == GAP_RECV && !for_sender))
			return 56;
		return 0;
	endfunction

	function automatic longint floor_quot(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// bridge equation solved for the sensor, then the linear fit in centidegrees
	function automatic scan_word_t with_reading(scan_word_t w, logic [15:0] code);
		longint n, r1, r2, s, vq, v0q, num, den, qi, rem, rq, t;
		n = (code < 16'd32768) ? longint'(code) : longint'(code) - 64'sd65535;
		r1 = longint'(r1_q);
		r2 = longint'(r2_q);
		s = r1 + r2;
		vq = 64'sd256 * n;
		v0q = 64'sd32767 * longint'(v0_q);
		num = r1 * (vq * s + v0q * r2);
		den = (v0q - vq) * s - v0q * r2;
		if (den <= 0) begin
			w.tvalid = 1'b0;
			w.temp = '0;
			w.rerr = 1'b1;
			return w;
		end
		w.tvalid = 1'b1;
		w.rerr = 1'b0;
		if (num >= 64'sd4096 * den) begin
			t = 32767;
			w.rerr = 1'b1;
		end else if (num < -64'sd4096 * den) begin
			t = -32768;
			w.rerr = 1'b1;
		end else begin
			qi = floor_quot(num, den);
			rem = num - qi * den;
			rq = qi * 64'sd65536 + (rem * 64'sd65536) / den;
			t = floor_quot(64'sd258137 * rq - 64'sd257990783 * 64'sd65536 + 64'sd327680000,
				64'sd655360000);
			if (t > 32767) begin
				t = 32767;
				w.rerr = 1'b1;
			end
			if (t < -32768) begin
				t = -32768;
				w.rerr = 1'b1;
			end
		end
		w.temp = t[15:0];
		return w;
	endfunction

	task automatic predict_tick(input logic err, input logic [15:0] code);
		scan_word_t w;
		logic [1:0] ch;
		logic [1:0] nxt;
		ch = (seq_chan >= 2'd2) ? 2'd2 : seq_chan;
		nxt = (ch == 2'd2) ? 2'd0 : ch + 2'd1;
		w = '0;
		w.chan = ch;
		if (err) begin
			w.action = ACT_SKIP;
			seq_phase = PH_CFG;
			seq_chan = nxt;
		end else if (seq_phase == PH_CFG) begin
			w.action = ACT_CFG;
			w.cfg_hi = mux_q[ch];
			w.cfg_lo = rate_q;
			seq_phase = PH_PTR;
		end else if (seq_phase == PH_PTR) begin
			w.action = ACT_PTR;
			seq_phase = PH_READ;
		end else begin
			w.action = ACT_READ;
			w = with_reading(w, code);
			seq_phase = PH_CFG;
			seq_chan = nxt;
		end
		expected_words.push_back(w);
	endtask

	task automatic cmp_field(input string name, input longint want, input longint got);
		if (want != got) begin
			n_errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// driver: the next word may be offered as soon as the current one is taken, unless a random gap holds it back
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_tick(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= idle_pct(gap, 1'b1)) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_ticks[0].err;
					s_tdata <= pending_ticks[0].code;
					void'(pending_ticks.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		scan_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					n_errors++;
					$error("word with nothing expected: action %0d tdata %h", m_tuser, m_tdata);
				end else begin
					want = expected_words.pop_front();
					cmp_field("bus_action", want.action, m_tuser);
					cmp_field("channel", want.chan, m_tdata[1:0]);
					cmp_field("config_high", want.cfg_hi, m_tdata[9:2]);
					cmp_field("config_low", want.cfg_lo, m_tdata[17:10]);
					cmp_field("temp_valid", want.tvalid, m_tdata[18]);
					cmp_field("temperature_centi", want.temp, $signed(m_tdata[34:19]));
					cmp_field("range_error", want.rerr, m_tdata[35]);
				end
			end
			// long hold-off so the output register fills and the input stalls
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= idle_pct(gap, 1'b0));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_MUX0: mux_q[0] = val[7:0];
			REG_MUX1: mux_q[1] = val[7:0];
			REG_MUX2: mux_q[2] = val[7:0];
			REG_RATE: rate_q = val[7:0];
			REG_R1:   r1_q = val;
			REG_R2:   r2_q = val;
			REG_V0:   v0_q = val[12:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic apply_config(input logic [15:0] m0, input logic [15:0] m1,
		input logic [15:0] m2, input logic [15:0] rate, input logic [15:0] r1,
		input logic [15:0] r2, input logic [15:0] v0);
		write_reg(REG_MUX0, m0);
		write_reg(REG_MUX1, m1);
		write_reg(REG_MUX2, m2);
		write_reg(REG_RATE, rate);
		write_reg(REG_R1, r1);
		write_reg(REG_R2, r2);
		write_reg(REG_V0, v0);
	endtask

	task automatic apply_random_config();
		logic [15:0] r2;
		r2 = $urandom_range(0, 1) ? 16'($urandom_range(100, 2200)) : 16'($urandom_range(1, 65535));
		apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(1, 65535)), r2, 16'($urandom_range(1, 6000)));
	endtask

	task automatic push_tick(input logic err, input logic [15:0] code);
		tick_t t;
		t.err = err;
		t.code = code;
		pending_ticks.push_back(t);
	endtask

	function automatic logic [15:0] rand_code();
		case ($urandom_range(0, 3))
			0, 1: return 16'($urandom_range(0, 65535));
			2: return $urandom_range(0, 1) ? 16'($urandom_range(0, 3000))
				: 16'($urandom_range(62535, 65535));
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'h7FFF;
					2: return 16'h8000;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	// block is idle once every word is back, since each tick gives one word
	task automatic drain();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || s_tvalid || expected_words.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random(input gap_mode_t m, input int count, input int hold);
		@(negedge clk);
		gap = m;
		hold_left = hold;
		// mostly clean cfg/ptr/read runs, a few bus errors mixed in
		for (int i = 0; i < count; i++)
			push_tick($urandom_range(0, 99) < 8, rand_code());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		gap = GAP_NONE;
		hold_left = 0;
		n_errors = 0;
		quiet_cycles = 0;
		seq_phase = PH_CFG;
		seq_chan = 2'd0;
		mux_q[0] = 8'd0;
		mux_q[1] = 8'd0;
		mux_q[2] = 8'd0;
		rate_q = 8'd227;
		r1_q = 16'd10000;
		r2_q = 16'd1000;
		v0_q = 13'd5000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: code extremes in reads, bus error in each phase
		@(negedge clk);
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'h0000);
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'h7FFF);
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'h8000);
		push_tick(1'b1, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b1, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b1, 16'hFFFF);
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'($urandom));
		push_tick(1'b0, 16'h0001);
		drain();

		apply_config(16'h00, 16'hFF, 16'h5A, 16'h00, 16'd10000, 16'd1000, 16'd5000);
		run_random(GAP_NONE, 100, 0);
		apply_config(16'hFF, 16'h00, 16'hA5, 16'hFF, 16'd65535, 16'd65535, 16'd6000);
		run_random(GAP_SEND, 100, 0);
		// tiny supply: denominator goes non-positive for most positive codes
		apply_config(16'h12, 16'h34, 16'h56, 16'hE3, 16'd1, 16'd1, 16'd1);
		run_random(GAP_RECV, 100, 0);
		apply_random_config();
		run_random(GAP_NONE, 100, HOLD_CYCLES);
		// large bottom resistor drives the reading into saturation
		apply_config(16'hC3, 16'h3C, 16'h81, 16'h7E, 16'd1000, 16'd65535, 16'd6000);
		run_random(GAP_BOTH, 100, 0);
		apply_random_config();
		run_random(GAP_SEND, 100, 0);
		apply_random_config();
		run_random(GAP_RECV, 100, 0);
		apply_random_config();
		run_random(GAP_BOTH, 100, 0);
		// registers written beyond their ranges, kept at their register widths
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		run_random(GAP_NONE, 60, 0);
		apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0);
		run_random(GAP_BOTH, 30, 0);

		repeat (80) @(posedge clk);
		if (n_errors == 0 && expected_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/abts_pkg.sv
rtl/abts_div.sv
rtl/adc_bridge_temperature_scanner_top.sv
tb/sv/tb_adc_bridge_temperature_scanner_top.sv
